### rtl/core/ialst_pkg.sv
`default_nettype none

package ialst_pkg;

  // storage shape; the widths of the position and count fields follow from the depth
  localparam int DEPTH        = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int POS_BITS     = $clog2(DEPTH);
  localparam int COUNT_BITS   = $clog2(DEPTH + 1);

  typedef logic [ELEMENT_BITS-1:0] element_t;
  typedef logic [POS_BITS-1:0]     pos_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  // operation codes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // command broadcast along the row of cells
  localparam logic [1:0] CMD_HOLD  = 2'd0;
  localparam logic [1:0] CMD_INS   = 2'd1;
  localparam logic [1:0] CMD_ERA   = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    pos_t       pos;
    count_t     count;
    element_t   element;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/ialst_cell.sv
`default_nettype none

module ialst_cell
  import ialst_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire element_t  left_data,
  input  wire element_t  right_data,
  output element_t       data
);

  localparam count_t IDX      = COUNT_BITS'(INDEX);
  localparam count_t IDX_NEXT = COUNT_BITS'(INDEX + 1);

  element_t data_r;
  element_t data_nxt;
  count_t   pos_ext;

  assign pos_ext = {1'b0, ctl.pos};

  always_comb begin
    data_nxt = data_r;
    case (ctl.cmd)
      CMD_INS: begin
        if (IDX == pos_ext) begin
          data_nxt = ctl.element;
        end else if ((IDX > pos_ext) && (IDX <= ctl.count)) begin
          data_nxt = left_data;
        end
      end
      CMD_ERA: begin
        if ((IDX >= pos_ext) && (IDX_NEXT < ctl.count)) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

### rtl/core/indexed_insert_erase_list.sv
`default_nettype none

// indexed_insert_erase_list
// an ordered array of up to 16 elements of 32 bits, kept from index 0, with
// an element count. each request on the in_ channel carries an operation
// (push, pop, insert, erase, read, clear), a position and an element; each
// request gives exactly one result on the out_ channel with a status, the
// element read (zero unless a read succeeds) and the count afterwards.
// the result of an accepted request is registered and shows in the cycle
// after it is accepted. one request is taken per cycle while the receiver
// keeps up, as the whole row of cells shifts up or down at once and the
// count register is updated alongside it.
// the result sits in an output register; a new request is taken while it
// waits only when out_ready takes the old result in the same cycle, so a
// stalled receiver holds back the in_ channel and nothing is lost.
// reset (rst_n low, synchronous) empties the array and drops any pending
// result; element storage itself is not cleared, entries at or above the
// count are never read.
// a full array refuses push, and insert at a valid index, with status full.

module indexed_insert_erase_list
  import ialst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [3:0]  in_position,
  input  wire logic [31:0] in_element_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_element_out,
  output logic [4:0]       out_count
);

  localparam count_t FULL_COUNT = COUNT_BITS'(DEPTH);

  logic      in_fire;
  count_t    count_r, count_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic [1:0] status_nxt, out_status_r;
  element_t  read_nxt, out_element_r;
  cell_ctl_t ctl;
  count_t    pos_ext;
  element_t  cell_data [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign pos_ext  = {1'b0, in_position};

  // decode the request: status, new count, read data and the command
  // broadcast to the row of cells
  always_comb begin
    status_nxt  = ST_OK;
    count_nxt   = count_r;
    read_nxt    = '0;
    ctl.cmd     = CMD_HOLD;
    ctl.pos     = in_position;
    ctl.count   = count_r;
    ctl.element = in_element_in;
    case (in_operation)
      OP_PUSH: begin
        if (count_r >= FULL_COUNT) begin
          status_nxt = ST_FULL;
        end else begin
          // a push is an insert at the end
          ctl.cmd   = CMD_INS;
          ctl.pos   = count_r[POS_BITS-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      OP_INSERT: begin
        // index is checked before fullness
        if (pos_ext > count_r) begin
          status_nxt = ST_BAD_INDEX;
        end else if (count_r >= FULL_COUNT) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.cmd   = CMD_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_ERASE: begin
        if (pos_ext >= count_r) begin
          status_nxt = ST_BAD_INDEX;
        end else begin
          ctl.cmd   = CMD_ERA;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_READ: begin
        if (pos_ext >= count_r) begin
          status_nxt = ST_BAD_INDEX;
        end else begin
          read_nxt = cell_data[in_position];
        end
      end
      OP_CLEAR: count_nxt = '0;
      default: status_nxt = ST_OK;
    endcase
    // cells only move on an accepted request
    if (!in_fire) begin
      ctl.cmd = CMD_HOLD;
    end
  end

  // row of cells, each taking from its lower or upper neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    element_t left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    ialst_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  // output register holds the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r  <= status_nxt;
      out_element_r <= read_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element_out = out_element_r;
  assign out_count       = count_r;

  // an accepted push into a non-full array grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_operation == OP_PUSH) && (count_r < FULL_COUNT))
    |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not grow the count");

  // an accepted clear leaves the array empty
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_operation == OP_CLEAR)) |=> (count_r == '0))
    else $error("clear left elements behind");

  // a full status is only reported with the array full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (count_r == FULL_COUNT))
    else $error("full status with room left");

  // read data is only ever returned with an ok status
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_element_r != '0)) |-> (out_status_r == ST_OK))
    else $error("element returned with an error status");

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (count_r <= FULL_COUNT))
    else $error("count beyond capacity");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ialst_pkg::*;

  // spare operation codes, the block must leave the list untouched
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // receiver hold-off used to back the block up
  localparam int LONG_HOLD_CYCLES = 40;
  // longest idle gap the sender inserts before one request
  localparam int MAX_GAP = 20;
  // bound on the wait for outstanding results at the end
  localparam int DRAIN_LIMIT = 10000;

  typedef struct packed {
    logic [1:0] status;
    element_t   element;
    count_t     count;
  } list_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports, all inputs known from time zero
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_operation = OP_PUSH;
  pos_t       in_position = '0;
  element_t   in_element_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  element_t   out_element_out;
  count_t     out_count;

  indexed_insert_erase_list i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_element_in   (in_element_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_element_out (out_element_out),
    .out_count       (out_count)
  );

  // shadow of the list contents, updated once per accepted request
  element_t held_elems [DEPTH];
  count_t   held_count = '0;

  // results still owed by the block, oldest first
  list_result_t awaited_results [$];

  // traffic shaping, percentages out of a hundred
  int idle_pct = 0;
  int stall_pct = 0;
  // a long hold-off is asked for by bumping hold_asks; the receiver tracks it
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // stimulus steering: grow the list towards full, then shrink it towards empty
  logic growing = 1'b1;

  // bookkeeping
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  // apply one request to the shadow list and give back the result it earns
  function automatic list_result_t apply_list_op(logic [2:0] op, pos_t pos, element_t elem);
    list_result_t res;
    int idx;
    res = '{status: ST_OK, element: '0, count: '0};
    case (op)
      OP_PUSH: begin
        if (held_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_elems[held_count[POS_BITS-1:0]] = elem;
          held_count++;
        end
      end
      OP_POP: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held_count--;
        end
      end
      OP_INSERT: begin
        // index is checked before fullness; index equal to count appends
        if (pos > held_count) begin
          res.status = ST_BAD_INDEX;
        end else if (held_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (idx = held_count; idx > pos; idx--) begin
            held_elems[pos_t'(idx)] = held_elems[pos_t'(idx-1)];
          end
          held_elems[pos] = elem;
          held_count++;
        end
      end
      OP_ERASE: begin
        if (pos >= held_count) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (idx = pos; idx + 1 < held_count; idx++) begin
            held_elems[pos_t'(idx)] = held_elems[pos_t'(idx+1)];
          end
          held_count--;
        end
      end
      OP_READ: begin
        if (pos >= held_count) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.element = held_elems[pos];
        end
      end
      OP_CLEAR: begin
        held_count = '0;
      end
      default: begin
        // spare codes leave everything as it is
      end
    endcase
    res.count = held_count;
    return res;
  endfunction

  // offer one request, wait for its handshake, then note the result it owes
  // called at a rising edge; valid is only dropped when an idle gap is taken
  task automatic send_request(logic [2:0] op, pos_t pos, element_t elem);
    int gap;
    list_result_t owed;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_position   <= pos;
    in_element_in <= elem;
    do @(posedge clk); while (in_ready !== 1'b1);
    owed = apply_list_op(op, pos, elem);
    awaited_results = {awaited_results, owed};
    requests_sent++;
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare every accepted result with the oldest one still owed
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status %0d element %h count %0d",
                 $time, out_status, out_element_out, out_count);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        status_tally[out_status]++;
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_element_out !== want.element) begin
          error_count++;
          $display("%0t: element expected %h actual %h", $time, want.element,
                   out_element_out);
        end
        if (out_count !== want.count) begin
          error_count++;
          $display("%0t: count expected %0d actual %0d", $time, want.count, out_count);
        end
      end
    end
  end

  // empty-list corner cases, field extremes, every operation once or more
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(OP_POP,    4'd0,  '0);             // pop on empty
    send_request(OP_READ,   4'd0,  '0);             // read on empty
    send_request(OP_ERASE,  4'd0,  '0);             // erase on empty
    send_request(OP_INSERT, 4'd1,  32'h1234_5678);  // insert past the end
    send_request(OP_INSERT, 4'd0,  32'hFFFF_FFFF);  // insert into empty list
    send_request(OP_PUSH,   4'd15, 32'h0000_0000);
    send_request(OP_INSERT, 4'd2,  32'hA5A5_A5A5);  // index equal to count appends
    send_request(OP_INSERT, 4'd0,  32'h5A5A_5A5A);  // shifts everything up
    send_request(OP_READ,   4'd3,  '1);
    send_request(OP_READ,   4'd0,  '0);
    send_request(OP_READ,   4'd4,  '0);             // read just past the end
    send_request(OP_ERASE,  4'd3,  '0);             // erase last element
    send_request(OP_ERASE,  4'd0,  '0);             // erase first, rest shift down
    send_request(OP_READ,   4'd1,  '0);
    send_request(OP_SPARE_6, 4'd15, '1);
    send_request(OP_SPARE_7, 4'd15, '1);
    send_request(OP_POP,    4'd0,  '0);
    send_request(OP_CLEAR,  4'd9,  '1);
    send_request(OP_READ,   4'd0,  '0);             // nothing left after clear
  endtask

  // fill to capacity, then push and insert against a full list
  task automatic test_full_list();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    send_request(OP_CLEAR, 4'd0, '0);
    for (k = 0; k < DEPTH; k++) begin
      if (k % 2 == 0) send_request(OP_PUSH, 4'd0, $urandom());
      else send_request(OP_INSERT, pos_t'($urandom_range(held_count)), $urandom());
    end
    send_request(OP_PUSH,   4'd0,  32'hDEAD_BEEF);  // push when full
    send_request(OP_INSERT, 4'd15, 32'hDEAD_BEEF);  // insert when full
    send_request(OP_INSERT, 4'd0,  32'hDEAD_BEEF);
    send_request(OP_READ,   4'd15, '0);
    send_request(OP_ERASE,  4'd15, '0);
    send_request(OP_INSERT, 4'd15, 32'hFFFF_0000);  // append back into the top slot
    send_request(OP_ERASE,  4'd0,  '0);
    send_request(OP_READ,   4'd14, '0);
  endtask

  // random mix that swings the list between empty and full
  task automatic test_random_mix(int n, int idle, int stall);
    logic [2:0] op;
    pos_t       pos;
    element_t   elem;
    int         r;
    logic [2:0] grow_op;
    logic [2:0] shrink_op;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) begin
      if (held_count == DEPTH) growing = 1'b0;
      else if (held_count == 0) growing = 1'b1;
      grow_op   = ($urandom_range(1) == 0) ? OP_PUSH : OP_INSERT;
      shrink_op = ($urandom_range(1) == 0) ? OP_POP : OP_ERASE;
      r = $urandom_range(99);
      if (r < 3) op = ($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
      else if (r < 5) op = OP_CLEAR;
      else if (r < 20) op = OP_READ;
      else if (r < 75) op = growing ? grow_op : shrink_op;
      else op = growing ? shrink_op : grow_op;
      // mostly valid indexes, now and then anything at all
      if ($urandom_range(9) == 0 || held_count == 0) pos = pos_t'($urandom_range(15));
      else if (op == OP_INSERT) pos = pos_t'($urandom_range(held_count > 15 ? 15 : held_count));
      else pos = pos_t'($urandom_range(held_count - 1));
      r = $urandom_range(15);
      if (r == 0) elem = '0;
      else if (r == 1) elem = '1;
      else elem = $urandom();
      send_request(op, pos, elem);
    end
  endtask

  // receiver holds off while requests keep coming, so the block stalls its input
  task automatic test_long_hold();
    hold_asks++;
    test_random_mix(30, 0, 0);
  endtask

  // overall sequence
  initial begin : run
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_list();
    test_long_hold();
    test_random_mix(120, 0, 0);
    test_random_mix(120, 66, 0);
    test_random_mix(120, 0, 66);
    test_random_mix(120, 33, 33);
    in_valid <= 1'b0;
    // wait for the last results, then idle on for anything stray
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
    $display("ran %0d requests, %0d results checked, across four idle/stall mixes",
             requests_sent, results_checked);
    $display("statuses seen: ok %0d, bad index %0d, full %0d, empty %0d",
             status_tally[ST_OK], status_tally[ST_BAD_INDEX], status_tally[ST_FULL],
             status_tally[ST_EMPTY]);
    if (error_count == 0) begin
      $display("indexed_insert_erase_list: match");
    end else begin
      $display("indexed_insert_erase_list: mismatch");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #1_000_000;
    $display("indexed_insert_erase_list: mismatch");
    $finish;
  end

endmodule
